/* rtl/u8sd_pkg.sv */
// Shared types and constants for the UTF-8 stream decoder.
// No dependencies; imported by every module of the block.
package u8sd_pkg;

	localparam int CP_W = 21;

	// Replacement character '?' for invalid or broken bytes.
	localparam logic [CP_W-1:0] REPL_CP = CP_W'(8'h3F);

	// Sequence lengths held in the open-sequence register.
	localparam logic [2:0] LEN_NONE = 3'd0;
	localparam logic [2:0] LEN_TWO = 3'd2;
	localparam logic [2:0] LEN_THREE = 3'd3;
	localparam logic [2:0] LEN_FOUR = 3'd4;

	// One request for the back end: pre_cnt replacement results, then one tail result.
	typedef struct packed {
		logic [1:0] pre_cnt;
		logic [CP_W-1:0] tail_cp;
		logic tail_rep;
	} job_t;

endpackage

/* rtl/u8sd_front.sv */
// Front end of the UTF-8 stream decoder: classifies bytes, tracks the open sequence.
// Depends on u8sd_pkg; emits one job_t per byte that causes results.
module u8sd_front import u8sd_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic accept,
	input logic [7:0] data_byte,
	input logic end_of_text,
	output logic push,
	output job_t job
);

	logic [7:0] pend0_q, pend1_q, pend2_q;
	logic [1:0] cnt_q;
	logic [2:0] exp_q;

	logic seq_open, is_cont, completes;
	logic [2:0] cnt_ext;
	logic [2:0] lead_len;
	logic lead_byte;
	logic has_job;
	logic [1:0] cnt_d;
	logic [2:0] exp_d;
	logic wr_pend0, wr_cont;
	logic [CP_W-1:0] full_cp;

	assign seq_open = (exp_q != LEN_NONE);
	assign is_cont = (data_byte[7:6] == 2'b10);
	assign cnt_ext = {1'b0, cnt_q};
	assign completes = ((cnt_ext + 3'd1) >= exp_q);

	// Assemble the finished code point from the buffered lead and continuations.
	always_comb begin
		full_cp = '0;
		case (exp_q)
			LEN_TWO: full_cp = CP_W'({pend0_q[4:0], data_byte[5:0]});
			LEN_THREE: full_cp = CP_W'({pend0_q[3:0], pend1_q[5:0], data_byte[5:0]});
			LEN_FOUR: full_cp = {pend0_q[2:0], pend1_q[5:0], pend2_q[5:0], data_byte[5:0]};
			default: full_cp = '0;
		endcase
	end

	// Lead byte class of the incoming byte.
	always_comb begin
		lead_byte = 1'b0;
		lead_len = LEN_NONE;
		if (data_byte[7:5] == 3'b110) begin
			lead_byte = 1'b1;
			lead_len = LEN_TWO;
		end else if (data_byte[7:4] == 4'b1110) begin
			lead_byte = 1'b1;
			lead_len = LEN_THREE;
		end else if (data_byte[7:3] == 5'b11110) begin
			lead_byte = 1'b1;
			lead_len = LEN_FOUR;
		end
	end

	// Decide the results of this byte and the next sequence state.
	always_comb begin
		has_job = 1'b0;
		job.pre_cnt = 2'd0;
		job.tail_cp = REPL_CP;
		job.tail_rep = 1'b1;
		cnt_d = cnt_q;
		exp_d = exp_q;
		wr_pend0 = 1'b0;
		wr_cont = 1'b0;
		if (seq_open && is_cont) begin
			if (completes) begin
				has_job = 1'b1;
				job.tail_cp = full_cp;
				job.tail_rep = 1'b0;
				cnt_d = 2'd0;
				exp_d = LEN_NONE;
			end else begin
				wr_cont = 1'b1;
				cnt_d = cnt_q + 2'd1;
				if (end_of_text) begin
					// Early end: every buffered byte, this one included, becomes '?'.
					has_job = 1'b1;
					job.pre_cnt = cnt_q;
					cnt_d = 2'd0;
					exp_d = LEN_NONE;
				end
			end
		end else begin
			// A broken sequence is flushed first, then the byte is decoded afresh.
			job.pre_cnt = seq_open ? cnt_q : 2'd0;
			cnt_d = 2'd0;
			exp_d = LEN_NONE;
			if (!data_byte[7]) begin
				has_job = 1'b1;
				job.tail_cp = CP_W'(data_byte);
				job.tail_rep = 1'b0;
			end else if (lead_byte && !end_of_text) begin
				wr_pend0 = 1'b1;
				cnt_d = 2'd1;
				exp_d = lead_len;
				// No fresh result: the last flushed '?' becomes the tail.
				if (seq_open) begin
					has_job = 1'b1;
					job.pre_cnt = cnt_q - 2'd1;
				end
			end else begin
				has_job = 1'b1;
			end
		end
	end

	assign push = accept && has_job;

	// Sequence control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
			exp_q <= LEN_NONE;
		end else if (accept) begin
			cnt_q <= cnt_d;
			exp_q <= exp_d;
		end
	end

	// Buffered sequence bytes.
	always_ff @(posedge clk) begin
		if (accept && wr_pend0) begin
			pend0_q <= data_byte;
		end
		if (accept && wr_cont) begin
			case (cnt_q)
				2'd1: pend1_q <= data_byte;
				2'd2: pend2_q <= data_byte;
				default: ;
			endcase
		end
	end

endmodule

/* rtl/u8sd_queue.sv */
// Small register queue of decode jobs between the front and back ends.
// Depends on u8sd_pkg for job_t.
module u8sd_queue import u8sd_pkg::*; #(
	parameter int DEPTH = 4
) (
	input logic clk,
	input logic arst_n,
	input logic push,
	input job_t push_data,
	output logic full,
	input logic pop,
	output job_t pop_data,
	output logic empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

	job_t slots_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full = (count_q == FULL_CNT);
	assign empty = (count_q == '0);
	assign pop_data = slots_q[rd_ptr_q];

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	// Job storage.
	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

/* rtl/u8sd_back.sv */
// Back end of the UTF-8 stream decoder: expands each job into result items.
// Depends on u8sd_pkg; drives the output channel from registers.
module u8sd_back import u8sd_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic q_empty,
	input job_t q_data,
	output logic q_pop,
	output logic out_valid,
	input logic out_ready,
	output logic [CP_W-1:0] code_point,
	output logic replaced,
	output logic last_of_run
);

	logic valid_q;
	logic [1:0] pre_left_q;
	logic [CP_W-1:0] tail_cp_q;
	logic tail_rep_q;
	logic on_tail, load;

	assign on_tail = (pre_left_q == 2'd0);
	// Take the next job when idle or when the tail result leaves.
	assign load = !valid_q || (out_ready && on_tail);
	assign q_pop = load && !q_empty;

	assign out_valid = valid_q;
	assign code_point = on_tail ? tail_cp_q : REPL_CP;
	assign replaced = on_tail ? tail_rep_q : 1'b1;
	assign last_of_run = on_tail;

	// Result sequencing.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			pre_left_q <= 2'd0;
		end else if (load) begin
			valid_q <= !q_empty;
			pre_left_q <= q_data.pre_cnt;
		end else if (out_ready) begin
			pre_left_q <= pre_left_q - 2'd1;
		end
	end

	// Tail payload of the current job.
	always_ff @(posedge clk) begin
		if (q_pop) begin
			tail_cp_q <= q_data.tail_cp;
			tail_rep_q <= q_data.tail_rep;
		end
	end

endmodule

/* rtl/utf8_stream_decoder_unit.sv */
// A byte's job enters the job queue when the byte is accepted; its first result then
// passes into the output register before it is offered. Throughput: one byte per
// cycle while each byte yields at most one result and the receiver is ready; a byte
// that yields several results holds the output register until all of them have left,
// and the job queue absorbs that until it fills. Reset clears the open sequence and
// empties the queue and output register at once; no clearing pass is needed.
// Depends on u8sd_pkg, u8sd_front, u8sd_queue and u8sd_back.
module utf8_stream_decoder_unit import u8sd_pkg::*; #(
	parameter int QUEUE_DEPTH = 4
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input logic [7:0] data_byte,
	input logic end_of_text,
	output logic out_valid,
	input logic out_ready,
	output logic [20:0] code_point,
	output logic replaced,
	output logic last_of_run
);

	logic accept, push, q_full, q_empty, q_pop;
	job_t push_job, pop_job;

	// Bytes are taken whenever the queue has room for a job.
	assign in_ready = !q_full;
	assign accept = in_valid && in_ready;

	u8sd_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.accept(accept),
		.data_byte(data_byte),
		.end_of_text(end_of_text),
		.push(push),
		.job(push_job)
	);

	u8sd_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_data(push_job),
		.full(q_full),
		.pop(q_pop),
		.pop_data(pop_job),
		.empty(q_empty)
	);

	u8sd_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.q_empty(q_empty),
		.q_data(pop_job),
		.q_pop(q_pop),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.code_point(code_point),
		.replaced(replaced),
		.last_of_run(last_of_run)
	);

endmodule

/* sim/utf8_stream_decoder_unit_tb.sv */
// Self-checking testbench for utf8_stream_decoder_unit: directed and random byte streams,
// with decoded code points predicted in a scoreboard and compared result by result.
// Depends on u8sd_pkg and the RTL of the decoder; reads no files.
module utf8_stream_decoder_unit_tb;
	import u8sd_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int RANDOM_ITEMS = 304;
	localparam int HOLD_CYCLES = 80;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int DRAIN_CYCLES = 8;
	localparam int BURST_ITEMS = 24;
	localparam int DIRECTED_N = 26;

	// Directed bytes as {end_of_text, data_byte}.
	localparam logic [8:0] DIRECTED [DIRECTED_N] = '{
		9'h000, 9'h07F, 9'h080, 9'h0BF, 9'h0F8, 9'h0FF,
		9'h0C3, 9'h0A9,
		9'h0E2, 9'h082, 9'h0AC,
		9'h0F7, 9'h0BF, 9'h0BF, 9'h0BF,
		9'h0E2, 9'h082, 9'h041,
		9'h0F0, 9'h09F, 9'h098, 9'h0DF, 9'h1BF,
		9'h0E2, 9'h182,
		9'h1C3
	};

	typedef struct packed {
		logic [CP_W-1:0] cp;
		logic rep;
		logic last;
	} cp_result_t;

	// Tracks the open UTF-8 sequence and queues the code points each request should produce.
	class cp_scoreboard;
		cp_result_t expected_cps[$];
		logic [7:0] held [3];
		int held_n;
		logic [2:0] seq_len;
		int errors;
		int results_seen;
		int replacements_seen;

		function new();
			held_n = 0;
			seq_len = LEN_NONE;
			errors = 0;
			results_seen = 0;
			replacements_seen = 0;
		endfunction

		function void add(logic [CP_W-1:0] cp, logic rep);
			cp_result_t r;
			r.cp = cp;
			r.rep = rep;
			r.last = 1'b0;
			expected_cps.push_back(r);
		endfunction

		function void flush_held();
			for (int i = 0; i < held_n; i++)
				add(REPL_CP, 1'b1);
			held_n = 0;
			seq_len = LEN_NONE;
		endfunction

		// Predicts the results of one accepted request.
		function void note_byte(logic [7:0] b, logic eot);
			int start;
			logic [CP_W-1:0] acc;
			cp_result_t tail;
			start = expected_cps.size();
			if (seq_len != LEN_NONE && b[7:6] == 2'b10) begin
				if (held_n + 1 >= int'(seq_len)) begin
					// The continuation completes the sequence.
					case (seq_len)
						LEN_TWO: acc = CP_W'(held[0][4:0]);
						LEN_THREE: acc = CP_W'(held[0][3:0]);
						default: acc = CP_W'(held[0][2:0]);
					endcase
					for (int i = 1; i < held_n; i++)
						acc = (acc << 6) | CP_W'(held[i][5:0]);
					acc = (acc << 6) | CP_W'(b[5:0]);
					held_n = 0;
					seq_len = LEN_NONE;
					add(acc, 1'b0);
				end else begin
					held[held_n] = b;
					held_n++;
					if (eot)
						flush_held();
				end
			end else begin
				// A non-continuation breaks any open sequence, then is decoded afresh.
				if (seq_len != LEN_NONE)
					flush_held();
				if (b < 8'h80) begin
					add(CP_W'(b), 1'b0);
				end else if (b[7:6] == 2'b10 || b >= 8'hF8) begin
					add(REPL_CP, 1'b1);
				end else if (eot) begin
					add(REPL_CP, 1'b1);
				end else begin
					held[0] = b;
					held_n = 1;
					if (b[7:5] == 3'b110)
						seq_len = LEN_TWO;
					else if (b[7:4] == 4'b1110)
						seq_len = LEN_THREE;
					else
						seq_len = LEN_FOUR;
				end
			end
			// The final result of the request carries the last flag.
			if (expected_cps.size() > start) begin
				tail = expected_cps.pop_back();
				tail.last = 1'b1;
				expected_cps.push_back(tail);
			end
		endfunction

		function void check_code_point(logic [CP_W-1:0] cp, logic rep, logic last);
			cp_result_t exp_r;
			results_seen++;
			if (rep)
				replacements_seen++;
			if (expected_cps.size() == 0) begin
				$display("%0t: unexpected result code_point %h replaced %b last %b",
					$time, cp, rep, last);
				errors++;
				return;
			end
			exp_r = expected_cps.pop_front();
			if (cp !== exp_r.cp) begin
				$display("%0t: code_point expected %h actual %h", $time, exp_r.cp, cp);
				errors++;
			end
			if (rep !== exp_r.rep) begin
				$display("%0t: replaced expected %b actual %b", $time, exp_r.rep, rep);
				errors++;
			end
			if (last !== exp_r.last) begin
				$display("%0t: last_of_run expected %b actual %b", $time, exp_r.last, last);
				errors++;
			end
		endfunction

		function int pending();
			return expected_cps.size();
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [7:0] data_byte = 8'h00;
	logic end_of_text = 1'b0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [20:0] code_point;
	logic replaced;
	logic last_of_run;

	cp_scoreboard sb = new();
	int items_sent = 0;
	bit burst_mode = 1'b0;
	bit tx_calm = 1'b0;
	bit rx_calm = 1'b0;
	bit hold_req = 1'b0;

	utf8_stream_decoder_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.data_byte(data_byte),
		.end_of_text(end_of_text),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.code_point(code_point),
		.replaced(replaced),
		.last_of_run(last_of_run)
	);

	always #4 clk = ~clk;

	// Mostly short idle gaps, a few long ones.
	function automatic int pick_gap(bit calm);
		int r;
		if (calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// Offers one request and waits for it to be accepted.
	task automatic send_byte(logic [7:0] b, logic eot);
		int gap;
		gap = pick_gap(burst_mode || tx_calm);
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		data_byte <= b;
		end_of_text <= eot;
		do @(posedge clk); while (!in_ready);
		sb.note_byte(b, eot);
		items_sent++;
		if ($urandom_range(0, 19) == 0)
			tx_calm = !tx_calm;
	endtask

	// Sends one random unit: a plain byte, a well-formed or broken sequence, or noise.
	task automatic send_random_unit();
		int kind;
		int len;
		int k;
		logic [7:0] b;
		kind = $urandom_range(0, 99);
		len = $urandom_range(2, 4);
		case (len)
			2: b = {3'b110, 5'($urandom)};
			3: b = {4'b1110, 4'($urandom)};
			default: b = {5'b11110, 3'($urandom)};
		endcase
		if (kind < 30) begin
			send_byte(8'($urandom_range(0, 127)), $urandom_range(0, 15) == 0);
		end else if (kind < 75) begin
			send_byte(b, 1'b0);
			for (int i = 1; i < len; i++)
				send_byte({2'b10, 6'($urandom)}, i == len - 1 && $urandom_range(0, 7) == 0);
		end else if (kind < 87) begin
			// Lead plus too few continuations, ended by a new byte or an early end flag.
			send_byte(b, 1'b0);
			k = $urandom_range(0, len - 2);
			for (int i = 0; i < k; i++)
				send_byte({2'b10, 6'($urandom)}, 1'b0);
			if ($urandom_range(0, 1) == 1 && k + 2 < len) begin
				send_byte({2'b10, 6'($urandom)}, 1'b1);
			end else begin
				b = 8'($urandom);
				if (b[7:6] == 2'b10)
					b[6] = 1'b1;
				send_byte(b, $urandom_range(0, 3) == 0);
			end
		end else begin
			send_byte(8'($urandom), $urandom_range(0, 3) == 0);
		end
	endtask

	// Receiver: random stalls, plus one long hold-off on request.
	initial begin
		int stall_left;
		stall_left = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				stall_left = HOLD_CYCLES;
			end
			if (stall_left > 0) begin
				out_ready <= 1'b0;
				stall_left--;
			end else begin
				out_ready <= 1'b1;
				if (!rx_calm && $urandom_range(0, 3) == 0)
					stall_left = pick_gap(1'b0);
				if ($urandom_range(0, 39) == 0)
					rx_calm = !rx_calm;
			end
		end
	end

	// Results are checked at the rising edge on which they are accepted.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_code_point(code_point, replaced, last_of_run);
	end

	// Watchdog: ends the run when no request moves on either side for too long.
	initial begin
		int quiet_cycles;
		quiet_cycles = 0;
		@(posedge arst_n);
		while (quiet_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
		$display("%0t: no request moved for %0d cycles", $time, WATCHDOG_LIMIT);
		$display("[FAIL] regression broken");
		$finish;
	end

	// Main stimulus.
	initial begin
		int burst_start;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed part: extremes, every byte class and each kind of broken sequence.
		for (int i = 0; i < DIRECTED_N; i++)
			send_byte(DIRECTED[i][7:0], DIRECTED[i][8]);

		// Random part, with one burst against a long output hold-off.
		while (items_sent < DIRECTED_N + RANDOM_ITEMS) begin
			if (items_sent >= DIRECTED_N + 120 && items_sent < DIRECTED_N + 130 && !burst_mode) begin
				burst_mode = 1'b1;
				hold_req = 1'b1;
				burst_start = items_sent;
				while (items_sent < burst_start + BURST_ITEMS)
					send_random_unit();
				burst_mode = 1'b0;
			end
			send_random_unit();
		end
		@(negedge clk);
		in_valid <= 1'b0;

		// Drain the outstanding results, then allow a few more cycles for strays.
		while (sb.pending() > 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d bytes; checked %0d code points, %0d of them replacements.",
			items_sent, sb.results_seen, sb.replacements_seen);
		$display("Covered plain, multi-byte, stray, invalid, broken and early-end input.");
		if (sb.errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

/* files.f */
rtl/u8sd_pkg.sv
rtl/u8sd_front.sv
rtl/u8sd_queue.sv
rtl/u8sd_back.sv
rtl/utf8_stream_decoder_unit.sv
sim/utf8_stream_decoder_unit_tb.sv
